[rtl/core/page_table_with_use_counts_core_assert.svh]
// Assertion macros for the page table port checker.
// No dependencies; included by bare file name.
`ifndef PAGE_TABLE_WITH_USE_COUNTS_CORE_ASSERT_SVH
`define PAGE_TABLE_WITH_USE_COUNTS_CORE_ASSERT_SVH

// Clocked check, cancelled while reset is active.
`define PTUC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("ptuc check failed");

// Clocked check that also runs through reset.
`define PTUC_ASSERT_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("ptuc check failed");

`endif

[rtl/core/ptuc_pkg.sv]
// Shared types and fixed constants of the page table core.
// No dependencies; imported by the core, its channel users and its checker.
package ptuc_pkg;

  localparam int VA_W  = 10;  // virt_address
  localparam int FI_W  = 6;   // frame_index
  localparam int PP_W  = 8;   // phys_page
  localparam int PA_W  = 12;  // phys_address
  localparam int LB_W  = 10;  // least_used_base
  localparam int CNT_W = 16;  // use counter

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
  localparam logic signed [CNT_W-1:0] CNT_ONE = 16'sh0001;

  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [FI_W-1:0] frame_index;
    logic [PP_W-1:0] phys_page;
    logic [VA_W-1:0] virt_address;
  } ptuc_req_t;

  typedef struct packed {
    logic            hit;
    logic [PA_W-1:0] phys_address;
    logic [LB_W-1:0] least_used_base;
  } ptuc_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } ptuc_state_t;

endpackage

[rtl/core/ptuc_chan_if.sv]
// Valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; the core uses ptuc_req_t and ptuc_rsp_t.
interface ptuc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/page_table_with_use_counts_core.sv]
// Page table with per-frame use counters, least-used frame report.
// Depends on ptuc_pkg, ptuc_chan_if, ptuc_div and ptuc_ram.
//
// Usage:
//   in_chan carries requests (map a frame to a page, or translate an
//   address); out_chan returns one result per request: hit flag, physical
//   address and the base address of the least-used mapped frame.
//   Requests are taken one at a time. Each goes through a reciprocal
//   divider (address split or page wrap), a lookup of the frame entry
//   when a translate falls inside the table, and a sweep that reads every
//   frame entry once (one per cycle), ages counters on a miss and tracks
//   the least-used frame.
//   After reset the frame memory is cleared entry by entry, with
//   in_chan.ready low throughout.
//   Results sit in an output register; the next request is taken while a
//   result waits, but its own result holds in the core until out_chan
//   is drained.
module page_table_with_use_counts_core
  import ptuc_pkg::*;
#(
  parameter int FRAMES     = 64,
  parameter int PAGE_BYTES = 16,
  parameter int PHYS_PAGES = 256
) (
  input  logic   clk,
  input  logic   rst_n,
  ptuc_chan_if.sink   in_chan,
  ptuc_chan_if.source out_chan
);

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int PAGE_W  = (PHYS_PAGES >= 256) ? PP_W : $clog2(PHYS_PAGES);
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int ENT_W   = 1 + PAGE_W + CNT_W;
  localparam int PROD_W  = PAGE_W + OFF_W + 1;
  localparam int IX_W    = VA_W + 1;

  localparam logic [IX_W-1:0]    FRAMES_X  = IX_W'(FRAMES);
  localparam logic [FRAME_W-1:0] LAST_IDX  = FRAME_W'(FRAMES - 1);
  localparam logic [LB_W-1:0]    BASE_STEP = LB_W'(PAGE_BYTES);

  ptuc_state_t state_r, state_nxt;

  ptuc_req_t                 req_r;
  logic [FRAME_W-1:0]        idx_r, idx_nxt;
  logic                      proc_vld_r;
  logic [FRAME_W-1:0]        proc_idx_r;
  logic [LB_W-1:0]           issue_base_r;
  logic [LB_W-1:0]           proc_base_r;
  logic [VA_W-1:0]           frame_r;
  logic [OFF_W-1:0]          off_r;
  logic                      age_r;
  logic                      hit_r;
  logic [PA_W-1:0]           paddr_r;
  logic signed [CNT_W-1:0]   best_cnt_r;
  logic [LB_W-1:0]           best_base_r;
  ptuc_rsp_t                 out_data_r;
  logic                      out_valid_r;

  logic                      in_accept;
  logic                      out_load;
  logic                      div_start;
  logic                      div_done;
  logic                      div_sel_b;
  logic [VA_W-1:0]           div_dividend;
  logic [VA_W-1:0]           div_quo;
  logic [VA_W-1:0]           div_rem;

  logic                      ram_we;
  logic [FRAME_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]          ram_wdata;
  logic                      ram_re;
  logic [FRAME_W-1:0]        ram_raddr;
  logic [ENT_W-1:0]          ram_rdata;

  logic                      rd_mapped;
  logic [PAGE_W-1:0]         rd_page;
  logic signed [CNT_W-1:0]   rd_cnt;
  logic signed [CNT_W-1:0]   cnt_inc;
  logic signed [CNT_W-1:0]   sweep_cnt;
  logic                      age_here;
  logic                      take_best;
  logic                      frame_in_table;
  logic                      map_in_table;
  logic [PROD_W-1:0]         paddr_sum;

  // ---------------------------------------------------------------- units
  ptuc_div #(
    .DVD_W (VA_W),
    .DIV_A (PAGE_BYTES),
    .DIV_B (PHYS_PAGES)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sel_b     (div_sel_b),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ptuc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------- datapath
  assign in_accept = in_chan.valid && in_chan.ready;

  assign div_sel_b    = (in_chan.data.req_type == REQ_MAP);
  assign div_dividend = (in_chan.data.req_type == REQ_XLATE) ?
                        in_chan.data.virt_address :
                        VA_W'(in_chan.data.phys_page);

  assign rd_mapped = ram_rdata[ENT_W-1];
  assign rd_page   = ram_rdata[CNT_W +: PAGE_W];
  assign rd_cnt    = ram_rdata[CNT_W-1:0];

  assign frame_in_table = ({1'b0, div_quo} < FRAMES_X);
  assign map_in_table   = (IX_W'(req_r.frame_index) < FRAMES_X);

  assign cnt_inc = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;

  // a miss ages every frame below the requested one (all, if off the table)
  assign age_here  = age_r && (IX_W'(proc_idx_r) < IX_W'(frame_r));
  assign sweep_cnt = (age_here && (rd_cnt != CNT_MIN)) ? rd_cnt - CNT_ONE : rd_cnt;

  // frame 0 seeds the search whether mapped or not; ties keep the lower frame
  assign take_best = (proc_idx_r == '0) || (rd_mapped && (sweep_cnt < best_cnt_r));

  assign paddr_sum = PROD_W'(rd_page) * PROD_W'(PAGE_BYTES) + PROD_W'(off_r);

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (req_r.req_type == REQ_XLATE && frame_in_table) begin
            state_nxt = ST_LOOK;
          end else begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_LOOK:  state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // -------------------------------------------------------------- outputs
  always_comb begin
    in_chan.ready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    idx_nxt       = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        div_start     = in_chan.valid;
      end
      ST_DIV: begin
        if (div_done) begin
          if (req_r.req_type == REQ_MAP) begin
            ram_we    = map_in_table;
            ram_waddr = FRAME_W'(req_r.frame_index);
            ram_wdata = {1'b1, div_rem[PAGE_W-1:0], {CNT_W{1'b0}}};
          end else begin
            ram_re    = frame_in_table;
            ram_raddr = div_quo[FRAME_W-1:0];
          end
        end
      end
      ST_LOOK: begin
        ram_we    = rd_mapped;
        ram_waddr = frame_r[FRAME_W-1:0];
        ram_wdata = {rd_mapped, rd_page, cnt_inc};
      end
      ST_SWEEP: begin
        ram_re  = 1'b1;
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      ST_DRAIN: begin
        idx_nxt = '0;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
    // write-back of an aged counter, one entry behind the read
    if (proc_vld_r && age_here) begin
      ram_we    = 1'b1;
      ram_waddr = proc_idx_r;
      ram_wdata = {rd_mapped, rd_page, sweep_cnt};
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      proc_vld_r <= (state_r == ST_SWEEP);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_chan.data;
    end
    if (state_r == ST_DIV && div_done) begin
      frame_r      <= div_quo;
      off_r        <= OFF_W'(div_rem);
      hit_r        <= 1'b0;
      paddr_r      <= '0;
      age_r        <= (req_r.req_type == REQ_XLATE) && !frame_in_table;
      issue_base_r <= '0;
    end
    if (state_r == ST_LOOK) begin
      if (rd_mapped) begin
        hit_r   <= 1'b1;
        paddr_r <= PA_W'(paddr_sum);
      end else begin
        age_r   <= 1'b1;
      end
    end
    if (state_r == ST_SWEEP) begin
      issue_base_r <= issue_base_r + BASE_STEP;
      proc_idx_r   <= idx_r;
      proc_base_r  <= issue_base_r;
    end
    if (proc_vld_r && take_best) begin
      best_cnt_r  <= sweep_cnt;
      best_base_r <= proc_base_r;
    end
    if (out_load) begin
      out_data_r <= '{hit: hit_r, phys_address: paddr_r, least_used_base: best_base_r};
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

[rtl/core/ptuc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ptuc_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ptuc_div.sv]
// Constant divider by reciprocal multiplication, one of two divisors per start.
// No dependencies; used by the page table core for address and page splits.
module ptuc_div #(
  parameter int DVD_W = 10,
  parameter int DIV_A = 16,
  parameter int DIV_B = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             sel_b,
  input  logic [DVD_W-1:0] dividend,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVD_W-1:0] remainder
);

  // q = (x * M) >> S, S = DVD_W + clog2(d), M = ceil(2^S / d): exact for x < 2^DVD_W
  localparam int     SH_A  = DVD_W + $clog2(DIV_A);
  localparam int     SH_B  = DVD_W + $clog2(DIV_B);
  localparam longint REC_A = ((longint'(1) << SH_A) + DIV_A - 1) / DIV_A;
  localparam longint REC_B = ((longint'(1) << SH_B) + DIV_B - 1) / DIV_B;
  localparam int     MUL_W = DVD_W + 1;
  localparam int     PRD_W = DVD_W + MUL_W;

  localparam logic [MUL_W-1:0] MUL_A = MUL_W'(REC_A);
  localparam logic [MUL_W-1:0] MUL_B = MUL_W'(REC_B);
  localparam logic [DVD_W-1:0] DVS_A = DVD_W'(DIV_A);
  localparam logic [DVD_W-1:0] DVS_B = DVD_W'(DIV_B);

  logic             quo_vld_r;
  logic             done_r;
  logic             sel_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVD_W-1:0] rem_r;
  logic [PRD_W-1:0] prod;
  logic [DVD_W-1:0] quo_nxt;
  logic [DVD_W-1:0] back_prod;

  assign prod    = PRD_W'(dividend) * PRD_W'(sel_b ? MUL_B : MUL_A);
  assign quo_nxt = sel_b ? DVD_W'(prod >> SH_B) : DVD_W'(prod >> SH_A);

  // quotient times divisor never exceeds the dividend, so DVD_W bits hold it
  assign back_prod = quo_r * (sel_r ? DVS_B : DVS_A);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      quo_vld_r <= start;
      done_r    <= quo_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      sel_r <= sel_b;
      quo_r <= quo_nxt;
    end
    if (quo_vld_r) begin
      rem_r <= dvd_r - back_prod;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/core/ptuc_checker.sv]
// Port-level checks of the page table core, bound into the core module.
// Depends on ptuc_pkg and page_table_with_use_counts_core_assert.svh.
`include "page_table_with_use_counts_core_assert.svh"

module ptuc_port_checker
  import ptuc_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_hit,
  input logic [PA_W-1:0] out_phys_address,
  input logic [LB_W-1:0] out_least_used_base
);

  logic [PA_W+LB_W:0] out_bits;

  assign out_bits = {out_hit, out_phys_address, out_least_used_base};

  `PTUC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `PTUC_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_bits))
  // one request in flight: busy right after a transaction is taken
  `PTUC_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  // map requests and misses report no address
  `PTUC_ASSERT(a_miss_no_addr, clk, rst_n, out_valid && !out_hit |-> out_phys_address == '0)
  // reset empties the output and starts the clearing sweep
  `PTUC_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid && !in_ready)

endmodule

bind page_table_with_use_counts_core ptuc_port_checker u_ptuc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_hit             (out_chan.data.hit),
  .out_phys_address    (out_chan.data.phys_address),
  .out_least_used_base (out_chan.data.least_used_base)
);

[tb/sv/ptuc_checker.sv]
// Transaction monitor and result predictor for the page table core.
// Depends on ptuc_pkg; watches both channels and counts mismatching results.
module ptuc_checker
  import ptuc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  ptuc_req_t in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  ptuc_rsp_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES     = 64;
  localparam int PAGE_BYTES = 16;
  localparam int PHYS_PAGES = 256;

  logic [PP_W-1:0]         frame_pg  [FRAMES];
  logic                    frame_on  [FRAMES];
  logic signed [CNT_W-1:0] use_cnt   [FRAMES];
  ptuc_rsp_t               rsp_expected_q [$];

  function automatic logic signed [CNT_W-1:0] clamp_count(input int v);
    if (v > CNT_MAX) return CNT_MAX;
    if (v < CNT_MIN) return CNT_MIN;
    return v[CNT_W-1:0];
  endfunction

  // Updates the shadow table and returns the result the core must give.
  function automatic ptuc_rsp_t apply_request(input ptuc_req_t req);
    ptuc_rsp_t rsp;
    int frame;
    int offset;
    int best;
    rsp = '0;
    if (req.req_type == REQ_MAP) begin
      if (req.frame_index < FRAMES) begin
        frame_pg[req.frame_index] = PP_W'(req.phys_page % PHYS_PAGES);
        frame_on[req.frame_index] = 1'b1;
        use_cnt[req.frame_index]  = '0;
      end
    end else begin
      frame  = req.virt_address / PAGE_BYTES;
      offset = req.virt_address % PAGE_BYTES;
      if (frame < FRAMES && frame_on[frame]) begin
        rsp.hit          = 1'b1;
        use_cnt[frame]   = clamp_count(int'(use_cnt[frame]) + 1);
        rsp.phys_address = PA_W'(int'(frame_pg[frame]) * PAGE_BYTES + offset);
      end else begin
        // miss ages every frame below the requested one
        for (int i = 0; i < ((frame < FRAMES) ? frame : FRAMES); i++)
          use_cnt[i] = clamp_count(int'(use_cnt[i]) - 1);
      end
    end
    // frame 0 is the starting candidate even when unmapped; ties keep the lower frame
    best = 0;
    for (int i = 0; i < FRAMES; i++)
      if (frame_on[i] && use_cnt[i] < use_cnt[best]) best = i;
    rsp.least_used_base = LB_W'(best * PAGE_BYTES);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    ptuc_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_pg[i] = '0;
        frame_on[i] = 1'b0;
        use_cnt[i]  = '0;
      end
      rsp_expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rsp_expected_q.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          want = rsp_expected_q.pop_front();
          if (out_data.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", out_data.hit, want.hit));
          if (out_data.phys_address !== want.phys_address)
            report_mismatch($sformatf("phys_address got 0x%03h want 0x%03h",
                                      out_data.phys_address, want.phys_address));
          if (out_data.least_used_base !== want.least_used_base)
            report_mismatch($sformatf("least_used_base got %0d want %0d",
                                      out_data.least_used_base, want.least_used_base));
        end
      end
      if (in_valid && in_ready)
        rsp_expected_q.push_back(apply_request(in_data));
    end
    pending = rsp_expected_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Stimulus and verdict for page_table_with_use_counts_core.
// Depends on ptuc_pkg, ptuc_chan_if, the core and ptuc_checker.
module tb_top;
  import ptuc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES     = 64;
  localparam int RAND_ITEMS = 450;

  logic clk;
  logic rst_n;
  bit   calm;
  int   fail_count;
  int   pending;
  int   mapped_list [$];
  bit   is_mapped [FRAMES];

  ptuc_chan_if #(.payload_t(ptuc_req_t)) req_if ();
  ptuc_chan_if #(.payload_t(ptuc_rsp_t)) rsp_if ();

  page_table_with_use_counts_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  ptuc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req_if.valid),
    .in_ready   (req_if.ready),
    .in_data    (req_if.data),
    .out_valid  (rsp_if.valid),
    .out_ready  (rsp_if.ready),
    .out_data   (rsp_if.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stall bursts until the closing stretch
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 12);
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  function automatic ptuc_req_t mk_req(input logic rt, input int fi, input int pp,
                                       input int va);
    ptuc_req_t r;
    r.req_type     = rt;
    r.frame_index  = FI_W'(fi);
    r.phys_page    = PP_W'(pp);
    r.virt_address = VA_W'(va);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_req(input ptuc_req_t r);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    if (r.req_type == REQ_MAP && !is_mapped[r.frame_index]) begin
      is_mapped[r.frame_index] = 1'b1;
      mapped_list.push_back(r.frame_index);
    end
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    ptuc_req_t r;
    int fr;
    rst_n        = 1'b0;
    calm         = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, edge frames, remap, ageing and ties
    send_req(mk_req(REQ_XLATE, 0, 0, 0));
    send_req(mk_req(REQ_XLATE, 0, 0, 1023));
    send_req(mk_req(REQ_MAP, 63, 255, 0));
    send_req(mk_req(REQ_MAP, 0, 0, 0));
    send_req(mk_req(REQ_XLATE, 0, 0, 1023));
    send_req(mk_req(REQ_XLATE, 0, 0, 0));
    send_req(mk_req(REQ_MAP, 5, 8'hAA, 0));
    send_req(mk_req(REQ_XLATE, 0, 0, 10 * 16 + 7));
    send_req(mk_req(REQ_XLATE, 0, 0, 5 * 16 + 15));
    send_req(mk_req(REQ_MAP, 42, 8'h55, 0));
    send_req(mk_req(REQ_XLATE, 0, 0, 43 * 16 + 3));
    send_req(mk_req(REQ_XLATE, 0, 0, 42 * 16 + 9));
    send_req(mk_req(REQ_MAP, 0, 8'h0F, 0));
    send_req(mk_req(REQ_XLATE, 0, 0, 15));
    send_req(mk_req(REQ_XLATE, 0, 0, 63 * 16));
    send_req(mk_req(REQ_MAP, 63, 255, 1023));
    send_req(mk_req(REQ_XLATE, 63, 255, 10'h2A5));
    send_req(mk_req(REQ_XLATE, 0, 0, 1023));
    send_req(mk_req(REQ_XLATE, 0, 0, 1 * 16 + 1));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) drain_results();
      if (i == RAND_ITEMS - 60) calm = 1'b1;
      r = mk_req(REQ_XLATE, $urandom_range(0, 63), $urandom_range(0, 255),
                 $urandom_range(0, 1023));
      if ($urandom_range(0, 99) < 22) begin
        r.req_type = REQ_MAP;
      end else if (mapped_list.size() != 0 && $urandom_range(0, 99) < 70) begin
        // mostly hits on mapped frames, random offset
        fr = mapped_list[$urandom_range(0, mapped_list.size() - 1)];
        r.virt_address = VA_W'(fr * 16 + $urandom_range(0, 15));
      end
      send_req(r);
    end

    drain_results();
    repeat (FRAMES + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
